[src/itoa_pkg.sv]
// Shared constants, types and helpers of the integer to ASCII formatter.
`timescale 1ns / 1ps
package itoa_pkg;

    localparam int ITOA_WORD_BITS = 32;
    localparam int STEP_BITS      = 4;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

    localparam logic OP_DECIMAL = 1'b0;
    localparam logic OP_BINARY  = 1'b1;

    typedef struct packed {
        logic mode;
        logic neg;
    } t_flags;

    function automatic int dec_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    function automatic int dabble_stages(input int bits);
        return (bits + STEP_BITS - 1) / STEP_BITS;
    endfunction

endpackage

[src/itoa_dabble.sv]
// One pipeline stage of the shift-and-add-three binary to BCD conversion.
`timescale 1ns / 1ps
module itoa_dabble import itoa_pkg::*; #(
    parameter int WORD_BITS = ITOA_WORD_BITS,
    parameter int DIGITS    = dec_digits(ITOA_WORD_BITS),
    parameter int OFFSET    = 0,
    parameter int STEPS     = STEP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_flags                i_flags,
    input  logic [WORD_BITS-1:0]  i_mag,
    input  logic [DIGITS*4-1:0]   i_bcd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_flags                o_flags,
    output logic [WORD_BITS-1:0]  o_mag,
    output logic [DIGITS*4-1:0]   o_bcd
);

    localparam int DW = DIGITS * 4;

    logic                 r_valid;
    t_flags               r_flags;
    logic [WORD_BITS-1:0] r_mag;
    logic [DW-1:0]        r_bcd;
    logic [DW-1:0]        n_bcd;

    always_comb begin
        n_bcd = i_bcd;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[DW-2:0], i_mag[WORD_BITS-1-OFFSET-s]};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_flags <= i_flags;
            r_mag   <= i_mag;
            r_bcd   <= n_bcd;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_mag   = r_mag;
    assign o_bcd   = r_bcd;

endmodule

[src/itoa_lead.sv]
// Pipeline stage that finds the most significant nonzero digit or bit.
`timescale 1ns / 1ps
module itoa_lead import itoa_pkg::*; #(
    parameter int WORD_BITS = ITOA_WORD_BITS,
    parameter int DIGITS    = dec_digits(ITOA_WORD_BITS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_flags                        i_flags,
    input  logic [WORD_BITS-1:0]          i_mag,
    input  logic [DIGITS*4-1:0]           i_bcd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_flags                        o_flags,
    output logic [WORD_BITS-1:0]          o_mag,
    output logic [DIGITS*4-1:0]           o_bcd,
    output logic [$clog2(WORD_BITS)-1:0]  o_top
);

    localparam int IW = $clog2(WORD_BITS);

    logic                 r_valid;
    t_flags               r_flags;
    logic [WORD_BITS-1:0] r_mag;
    logic [DIGITS*4-1:0]  r_bcd;
    logic [IW-1:0]        r_top;
    logic [IW-1:0]        n_top;

    always_comb begin
        n_top = '0;
        if (i_flags.mode == OP_BINARY) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                if (i_mag[b]) begin
                    n_top = IW'(b);
                end
            end
        end else begin
            for (int d = 0; d < DIGITS; d++) begin
                if (i_bcd[d*4 +: 4] != 4'd0) begin
                    n_top = IW'(d);
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_flags <= i_flags;
            r_mag   <= i_mag;
            r_bcd   <= i_bcd;
            r_top   <= n_top;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_mag   = r_mag;
    assign o_bcd   = r_bcd;
    assign o_top   = r_top;

endmodule

[src/itoa_serial.sv]
// Character emitter: sends the sign and then the digits one character at a time, held while the output is stalled.
`timescale 1ns / 1ps
module itoa_serial import itoa_pkg::*; #(
    parameter int WORD_BITS = ITOA_WORD_BITS,
    parameter int DIGITS    = dec_digits(ITOA_WORD_BITS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_flags                        i_flags,
    input  logic [WORD_BITS-1:0]          i_mag,
    input  logic [DIGITS*4-1:0]           i_bcd,
    input  logic [$clog2(WORD_BITS)-1:0]  i_top,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [7:0]                    o_char,
    output logic                          o_last
);

    localparam int IW  = $clog2(WORD_BITS);
    localparam int DIW = $clog2(DIGITS);
    localparam int DW  = DIGITS * 4;

    logic                 r_busy;
    logic                 r_neg_pend;
    logic                 r_mode;
    logic [IW-1:0]        r_idx;
    logic [WORD_BITS-1:0] r_mag;
    logic [DW-1:0]        r_bcd;
    logic                 r_out_valid;
    logic [7:0]           r_char;
    logic                 r_last;

    logic                 n_out_valid;
    logic [7:0]           n_char;
    logic                 n_last;
    logic                 w_out_free;
    logic                 w_emit;
    logic                 w_fin;
    logic                 w_load;
    logic [DIW+1:0]       w_sel;
    logic [3:0]           w_digit;

    assign w_out_free = !r_out_valid || i_tready;
    assign w_emit     = r_busy && w_out_free;
    assign w_fin      = w_emit && !r_neg_pend && (r_idx == '0);
    assign o_ready    = !r_busy || w_fin;
    assign w_load     = i_valid && o_ready;
    assign w_sel      = {r_idx[DIW-1:0], 2'b00};
    assign w_digit    = r_bcd[w_sel +: 4];

    always_comb begin
        n_out_valid = r_out_valid && !i_tready;
        n_char      = r_char;
        n_last      = r_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            if (r_neg_pend) begin
                n_char = CHAR_MINUS;
                n_last = 1'b0;
            end else begin
                n_last = (r_idx == '0);
                if (r_mode == OP_BINARY) begin
                    n_char = {CHAR_DIGIT_HI, 3'b000, r_mag[r_idx]};
                end else begin
                    n_char = {CHAR_DIGIT_HI, w_digit};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_neg_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_load) begin
                r_busy     <= 1'b1;
                r_neg_pend <= i_flags.neg;
            end else begin
                if (w_fin) begin
                    r_busy <= 1'b0;
                end
                if (w_emit) begin
                    r_neg_pend <= 1'b0;
                end
            end
        end
        r_char <= n_char;
        r_last <= n_last;
        if (w_load) begin
            r_mode <= i_flags.mode;
            r_idx  <= i_top;
            r_mag  <= i_mag;
            r_bcd  <= i_bcd;
        end else if (w_emit && !r_neg_pend && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_char   = r_char;
    assign o_last   = r_last;

    a_neg_only_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_neg_pend |-> (r_busy && (r_mode == OP_DECIMAL)))
        else $error("Sign pending outside a decimal number.");

    a_digit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_mode == OP_DECIMAL)) |-> (r_idx < IW'(DIGITS)))
        else $error("Decimal digit index beyond the digit count.");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_char == CHAR_MINUS)) |-> !r_last)
        else $error("A minus sign closed a number.");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_busy)
        else $error("A loaded number did not start.");

endmodule

[src/integer_to_ascii_formatter_top.sv]
// Top level of the integer to ASCII formatter.
//
//  Channel  | Direction | tdata                          | tuser        | tlast
//  ---------+-----------+--------------------------------+--------------+-------------
//  i_s_*    | in        | value (WORD_BITS, byte padded) | opcode       | -
//  o_m_*    | out       | character (8 bits)             | -            | last char
//
// A number occupies the emitter while its characters are sent: up to WORD_BITS
// characters in binary mode, up to the decimal digit count plus one for the sign.
// A word passes the input register, the BCD conversion stages, the digit search,
// the emitter load and the output register before its first character appears.
// Words enter the pipeline without gaps until the busy emitter holds them back.
// Reset is synchronous and active low and empties every stage.
// Stalls on the output hold every stage in place; nothing is lost or repeated.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_top import itoa_pkg::*; #(
    parameter int WORD_BITS = ITOA_WORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [((WORD_BITS+7)/8)*8-1:0]    i_s_tdata,  // value
    input  logic                              i_s_tuser,  // opcode
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [7:0]                        o_m_tdata,  // character
    output logic                              o_m_tlast
);

    localparam int DIGITS = dec_digits(WORD_BITS);
    localparam int NSTG   = dabble_stages(WORD_BITS);
    localparam int DW     = DIGITS * 4;
    localparam int IW     = $clog2(WORD_BITS);

    logic                 r_in_valid;
    t_flags               r_in_flags;
    logic [WORD_BITS-1:0] r_in_mag;
    logic                 w_in_ready;
    logic [WORD_BITS-1:0] w_value;
    t_flags               w_flags;

    logic                 w_v   [NSTG+1];
    logic                 w_rdy [NSTG+1];
    t_flags               w_f   [NSTG+1];
    logic [WORD_BITS-1:0] w_mag [NSTG+1];
    logic [DW-1:0]        w_bcd [NSTG+1];

    logic                 w_l_valid;
    logic                 w_l_ready;
    t_flags               w_l_flags;
    logic [WORD_BITS-1:0] w_l_mag;
    logic [DW-1:0]        w_l_bcd;
    logic [IW-1:0]        w_l_top;

    assign w_value    = i_s_tdata[WORD_BITS-1:0];
    assign w_flags    = {i_s_tuser, (i_s_tuser == OP_DECIMAL) && w_value[WORD_BITS-1]};
    assign w_in_ready = !r_in_valid || w_rdy[0];
    assign o_s_tready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (w_in_ready && i_s_tvalid) begin
            r_in_flags <= w_flags;
            r_in_mag   <= w_flags.neg ? (~w_value + 1'b1) : w_value;
        end
    end

    assign w_v[0]   = r_in_valid;
    assign w_f[0]   = r_in_flags;
    assign w_mag[0] = r_in_mag;
    assign w_bcd[0] = '0;

    for (genvar g = 0; g < NSTG; g++) begin : g_dabble
        localparam int REM   = WORD_BITS - g * STEP_BITS;
        localparam int STEPS = (REM < STEP_BITS) ? REM : STEP_BITS;

        itoa_dabble #(
            .WORD_BITS (WORD_BITS),
            .DIGITS    (DIGITS),
            .OFFSET    (g * STEP_BITS),
            .STEPS     (STEPS)
        ) u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_flags (w_f[g]),
            .i_mag   (w_mag[g]),
            .i_bcd   (w_bcd[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_flags (w_f[g+1]),
            .o_mag   (w_mag[g+1]),
            .o_bcd   (w_bcd[g+1])
        );
    end

    itoa_lead #(
        .WORD_BITS (WORD_BITS),
        .DIGITS    (DIGITS)
    ) u_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[NSTG]),
        .o_ready (w_rdy[NSTG]),
        .i_flags (w_f[NSTG]),
        .i_mag   (w_mag[NSTG]),
        .i_bcd   (w_bcd[NSTG]),
        .o_valid (w_l_valid),
        .i_ready (w_l_ready),
        .o_flags (w_l_flags),
        .o_mag   (w_l_mag),
        .o_bcd   (w_l_bcd),
        .o_top   (w_l_top)
    );

    itoa_serial #(
        .WORD_BITS (WORD_BITS),
        .DIGITS    (DIGITS)
    ) u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_l_valid),
        .o_ready  (w_l_ready),
        .i_flags  (w_l_flags),
        .i_mag    (w_l_mag),
        .i_bcd    (w_l_bcd),
        .i_top    (w_l_top),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_char   (o_m_tdata),
        .o_last   (o_m_tlast)
    );

endmodule
